// ===== src/sorted_table_binary_search_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sorted table search unit
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_UNIT_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication, masked during reset
`define STS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define STS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, active during reset
`define STS_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/sts_pkg.sv =====
// ---------------------------------------------------------------------------
// sts_pkg
// Shared types and codes of the sorted table search unit.
// ---------------------------------------------------------------------------
package sts_pkg;

  // command codes (input tuser)
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // register select (paddr[2])
  localparam logic REG_COUNT = 1'b0;
  localparam logic REG_MODE  = 1'b1;

  localparam int CountW = 11;
  localparam int IndexW = 10;
  localparam int ValueW = 32;
  localparam int BoundW = 13;

  // interval bound: covers -1 .. 2048
  typedef logic signed [BoundW-1:0] bound_t;

  typedef struct packed {
    logic              found;
    logic [IndexW-1:0] index;
  } sts_result_t;

endpackage

// ===== src/sts_ram.sv =====
// ---------------------------------------------------------------------------
// sts_ram
// Value table: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module sts_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/sts_seq.sv =====
// ---------------------------------------------------------------------------
// sts_seq
// Search sequencer: probes the midpoint, compares in one shared comparator,
// narrows the interval and holds the result until the output slot is free.
// ---------------------------------------------------------------------------
module sts_seq #(
  parameter int AW = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [31:0]           target_in,
  input  sts_pkg::bound_t       count,
  input  logic                  half_open,
  output logic                  busy,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  input  logic [31:0]           rd_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sts_pkg::sts_result_t  out_result
);

  import sts_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    PROBE,
    COMPARE,
    HOLD
  } state_t;

  state_t             state;
  bound_t             lo;
  bound_t             hi;
  bound_t             mid;
  bound_t             mid_next;
  bound_t             span;
  logic signed [31:0] target;
  logic signed [31:0] probe_val;
  logic               empty;
  logic               less;
  logic               equal;
  logic               out_load;
  sts_result_t        res;

  always_comb begin
    empty     = half_open ? (lo >= hi) : (lo > hi);
    span      = hi - lo;
    mid_next  = lo + (span >>> 1);
    rd_en     = (state == PROBE) && !empty;
    rd_addr   = AW'($unsigned(mid_next));
    probe_val = signed'(rd_data);
    less      = probe_val < target;
    equal     = probe_val == target;
    busy      = (state != IDLE);
    out_load  = (state == HOLD) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid  <= 1'b1;
        out_result <= res;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (start) begin
            target <= signed'(target_in);
            lo     <= '0;
            hi     <= half_open ? count : count - bound_t'(1);
            state  <= PROBE;
          end
        end
        PROBE: begin
          if (empty) begin
            res   <= '{found: 1'b0, index: '0};
            state <= HOLD;
          end else begin
            mid   <= mid_next;
            state <= COMPARE;
          end
        end
        COMPARE: begin
          priority if (equal) begin
            res   <= '{found: 1'b1, index: mid[IndexW-1:0]};
            state <= HOLD;
          end else if (less) begin
            lo    <= mid + bound_t'(1);
            state <= PROBE;
          end else begin
            hi    <= half_open ? mid : mid - bound_t'(1);
            state <= PROBE;
          end
        end
        HOLD: begin
          if (out_load) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== src/sorted_table_binary_search_unit.sv =====
// ---------------------------------------------------------------------------
// sorted_table_binary_search_unit
// Binary search over a written table of signed 32-bit values.
// ---------------------------------------------------------------------------
// Input stream (s_*): tuser[0] is the command. A write beat stores
// data_value at entry_index, with no result.
// A search beat looks for data_value among the first element_count entries.
// Output stream (m_*): one beat per search, found flag in tuser, index in
// tdata (zero when not found).
// Each halving step is a table RAM read at the midpoint, then a compare in
// the single shared comparator. s_tready is low from a search beat until
// its result is loaded into the output register.
// If m_tready is low, the result waits in the output register; writes and one
// more search are still taken, and that search then waits with s_tready low.
// Reset clears the sequencer state, the output valid and the APB registers;
// table contents are undefined until written. Registers via APB:
// element_count at 0x0, half_open_mode at 0x4; write them only while idle.
// ---------------------------------------------------------------------------
module sorted_table_binary_search_unit #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [9:0] entry_index, [41:10] data_value
  input  logic [0:0]  s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [9:0] match_index
  output logic [0:0]  m_tuser,   // [0] found
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import sts_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [16:0] DepthV = 17'(TABLE_DEPTH);

  logic [CountW-1:0] element_count;
  logic              half_open_mode;
  logic              cfg_wr;
  logic              s_acc;
  logic              busy;
  logic              ram_we;
  logic              start;
  logic [IndexW-1:0] entry_index;
  logic [31:0]       data_value;
  bound_t            count_clamped;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [31:0]       rd_data;
  sts_result_t       result;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count  <= '0;
      half_open_mode <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_COUNT: element_count  <= pwdata[CountW-1:0];
        REG_MODE:  half_open_mode <= pwdata[0];
        default:   ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_MODE) ? {31'b0, half_open_mode}
                                         : {21'b0, element_count};

  assign entry_index = s_tdata[9:0];
  assign data_value  = s_tdata[41:10];
  assign s_tready    = !busy;
  assign s_acc       = s_tvalid && s_tready;
  assign ram_we      = s_acc && (s_tuser[0] == CMD_WRITE)
                       && (17'(entry_index) < DepthV);
  assign start       = s_acc && (s_tuser[0] == CMD_SEARCH);

  assign count_clamped = (17'(element_count) > DepthV) ? bound_t'(TABLE_DEPTH)
                                                       : bound_t'(element_count);

  sts_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(entry_index)),
    .wdata (data_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  sts_seq #(
    .AW (AW)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .target_in  (data_value),
    .count      (count_clamped),
    .half_open  (half_open_mode),
    .busy       (busy),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result)
  );

  assign m_tdata = {6'b0, result.index};
  assign m_tuser = result.found;

endmodule

// ===== src/sts_checker.sv =====
// ---------------------------------------------------------------------------
// sts_checker
// Port-level checks of the sorted table search unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "sorted_table_binary_search_unit_defines.svh"

module sts_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [0:0]  m_tuser
);

  import sts_pkg::*;

  `STS_ASSERT_NEXT(a_search_busy, s_tvalid && s_tready && (s_tuser[0] == CMD_SEARCH), !s_tready, "input ready after search beat")
  `STS_ASSERT_NOW(a_miss_index, m_tvalid && !m_tuser[0], m_tdata[9:0] == 10'd0, "nonzero index on miss")
  `STS_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[15:10] == 6'd0, "tdata padding not zero")
  `STS_ASSERT_ALWAYS(a_reset_idle, rst, !m_tvalid, "output valid after reset")
  `STS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "output beat dropped")

endmodule

bind sorted_table_binary_search_unit sts_checker u_sts_checker (.*);

// ===== test/sorted_table_binary_search_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for sorted_table_binary_search_unit
// Writes the value table over the input stream, sets element_count and the
// interval mode over APB, and checks every search result against an
// in-bench binary search model. Traffic runs under random idling on both
// sides, one long output hold-off, and a full-table sweep of extreme counts.
// ---------------------------------------------------------------------------
module sorted_table_binary_search_unit_tb;
  import sts_pkg::*;

  localparam int DEPTH = 1024;
  localparam int PHASE_ITEMS = 15;
  localparam int NUM_PHASES = 12;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD = 300;
  localparam logic [2:0] ADDR_COUNT = {REG_COUNT, 2'b00};
  localparam logic [2:0] ADDR_MODE = {REG_MODE, 2'b00};

  class table_search_model;
    logic [ValueW-1:0] entry_val [DEPTH];
    bit written [DEPTH];
    int unsigned count_reg;
    bit half_open;
    sts_result_t pending_results [$];
    int errors;
    int writes;
    int searches;
    int hits;

    // returns 0 if the probe path touches an entry never written
    function bit lookup(logic signed [ValueW-1:0] target, output sts_result_t res);
      int n;
      int lo;
      int hi;
      int mid;
      bit safe;
      bit done;
      logic signed [ValueW-1:0] v;
      n = (count_reg > DEPTH) ? DEPTH : count_reg;
      lo = 0;
      hi = half_open ? n : n - 1;
      safe = 1'b1;
      done = 1'b0;
      res = '0;
      while (!done && (half_open ? (lo < hi) : (lo <= hi))) begin
        mid = lo + (hi - lo) / 2;
        if (!written[mid]) safe = 1'b0;
        v = entry_val[mid];
        if (v < target) begin
          lo = mid + 1;
        end else if (v > target) begin
          hi = half_open ? mid : mid - 1;
        end else begin
          res.found = 1'b1;
          res.index = mid[IndexW-1:0];
          done = 1'b1;
        end
      end
      return safe;
    endfunction

    function void note_beat(logic cmd, logic [IndexW-1:0] idx, logic [ValueW-1:0] val);
      sts_result_t res;
      if (cmd == CMD_WRITE) begin
        entry_val[idx] = val;
        written[idx] = 1'b1;
        writes++;
      end else begin
        void'(lookup(val, res));
        pending_results.push_back(res);
        searches++;
        if (res.found) hits++;
      end
    endfunction

    function void check_beat(logic found, logic [IndexW-1:0] idx);
      sts_result_t exp_res;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: found %0b index %0d", $time, found, idx);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (found !== exp_res.found) begin
          $display("%0t: found mismatch: expected %0b, got %0b", $time, exp_res.found, found);
          errors++;
        end
        if (idx !== exp_res.index) begin
          $display("%0t: match_index mismatch: expected %0d, got %0d",
                   $time, exp_res.index, idx);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [0:0] m_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  table_search_model model;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int stall_cycles;

  sorted_table_binary_search_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: check beats, drive m_tready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) model.check_beat(m_tuser[0], m_tdata[IndexW-1:0]);
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  task automatic push_item(input logic cmd, input logic [IndexW-1:0] idx,
                           input logic [ValueW-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {6'b0, val, idx};
    do @(posedge clk); while (!s_tready);
    model.note_beat(cmd, idx, val);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (model.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_COUNT) model.count_reg = 32'(value[CountW-1:0]);
    else model.half_open = value[0];
  endtask

  task automatic set_search(input int unsigned count, input bit mode);
    drain();
    write_reg(ADDR_COUNT, count);
    write_reg(ADDR_MODE, 32'(mode));
  endtask

  // ascending values over the whole table, with runs of duplicates
  task automatic fill_table;
    longint v;
    v = -64'sd2147483648;
    for (int i = 0; i < DEPTH; i++) begin
      if (i == DEPTH - 1) v = 64'sd2147483647;
      push_item(CMD_WRITE, i[IndexW-1:0], v[ValueW-1:0]);
      if ($urandom_range(0, 3) != 0) v += $urandom_range(1, 7000000);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
    end
  endtask

  task automatic random_item;
    int n_eff;
    int idx;
    int pick;
    logic [ValueW-1:0] val;
    sts_result_t res;
    n_eff = (model.count_reg > DEPTH) ? DEPTH : model.count_reg;
    if ($urandom_range(0, 99) < 15) begin
      if (n_eff > 0 && $urandom_range(0, 3) != 0) idx = $urandom_range(0, n_eff - 1);
      else idx = $urandom_range(0, DEPTH - 1);
      if (idx > 0 && $urandom_range(0, 1) == 0) val = model.entry_val[idx - 1];
      else val = $urandom;
      push_item(CMD_WRITE, idx[IndexW-1:0], val);
    end else begin
      idx = (n_eff > 0) ? $urandom_range(0, n_eff - 1) : $urandom_range(0, DEPTH - 1);
      pick = $urandom_range(0, 9);
      if (pick <= 5) val = model.entry_val[idx];
      else if (pick == 6) val = model.entry_val[idx] + ($urandom_range(0, 1) ? 1 : -1);
      else if (pick == 7) val = $urandom;
      else if (pick == 8) val = 32'h8000_0000;
      else val = 32'h7fff_ffff;
      if (model.lookup(val, res)) begin
        push_item(CMD_SEARCH, IndexW'($urandom_range(0, DEPTH - 1)), val);
      end else begin
        idx = -1;
        for (int i = 0; i < n_eff; i++) if (idx < 0 && !model.written[i]) idx = i;
        push_item(CMD_WRITE, idx[IndexW-1:0], val);
      end
    end
  endtask

  initial begin
    int unsigned counts [NUM_PHASES];
    bit modes [NUM_PHASES];
    model = new();
    counts = '{1, 2, 1024, 16, 2047, 0, 33, 1023, 1025, 5, 512, 1024};
    modes = '{0, 1, 0, 1, 1, 1, 0, 1, 0, 1, 0, 1};
    send_idle_pct = 21;
    recv_idle_pct = 53;
    hold_left = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty table after reset
    push_item(CMD_SEARCH, 10'h3ff, 32'h0000_0000);
    push_item(CMD_WRITE, 10'd0, 32'h8000_0000);
    push_item(CMD_WRITE, 10'd1, 32'(-5));
    push_item(CMD_WRITE, 10'd2, 32'd3);
    push_item(CMD_WRITE, 10'd3, 32'd3);
    push_item(CMD_WRITE, 10'd4, 32'd3);
    push_item(CMD_WRITE, 10'd5, 32'd100);
    push_item(CMD_WRITE, 10'd6, 32'h7fff_ffff);
    push_item(CMD_WRITE, 10'h3ff, 32'h7fff_ffff);
    // closed and half-open pick different duplicates of 3
    set_search(6, 1'b0);
    push_item(CMD_SEARCH, 10'd0, 32'd3);
    push_item(CMD_SEARCH, 10'd0, 32'h8000_0000);
    push_item(CMD_SEARCH, 10'd0, 32'h7fff_ffff);
    push_item(CMD_SEARCH, 10'd0, 32'(-6));
    push_item(CMD_SEARCH, 10'd0, 32'd100);
    set_search(7, 1'b1);
    push_item(CMD_SEARCH, 10'd0, 32'd3);
    push_item(CMD_SEARCH, 10'd0, 32'h7fff_ffff);
    push_item(CMD_SEARCH, 10'd0, 32'h8000_0000);
    push_item(CMD_SEARCH, 10'd0, 32'd101);

    fill_table();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_search(counts[p], modes[p]);
      if (p == 4) begin
        send_idle_pct = 53;
        recv_idle_pct = 21;
      end else if (p == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // output stalled long enough to back up the input
      if (p == 2) hold_left = LONG_HOLD;
      for (int k = 0; k < PHASE_ITEMS; k++) random_item();
    end

    drain();
    $display("%0d table writes, %0d searches, %0d found", model.writes, model.searches,
             model.hits);
    $display("element_count 0..2047 in both modes, long output stall, mixed idling");
    if (model.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
